/* rtl/core/atli_pkg.sv */
package atli_pkg;

  // Table geometry.
  localparam int ENTRIES = 16;
  localparam int SLOT_W  = $clog2(ENTRIES);

  // Key layout: protocol, host, port from high to low.
  localparam int HOST_W = 32;
  localparam int PORT_W = 16;
  localparam int KEY_W  = 1 + HOST_W + PORT_W;

  // Request kinds.
  localparam logic REQ_FIND = 1'b0;
  localparam logic REQ_FREE = 1'b1;

  // Result status codes.
  localparam logic [1:0] STATUS_FOUND    = 2'd0;
  localparam logic [1:0] STATUS_INSERTED = 2'd1;
  localparam logic [1:0] STATUS_FULL     = 2'd2;
  localparam logic [1:0] STATUS_UNUSED   = 2'd3;

  typedef logic [KEY_W-1:0]  key_t;
  typedef logic [SLOT_W-1:0] slot_t;

endpackage

/* rtl/core/address_table_lookup_insert.sv */
// Peer address table with lookup-or-insert and slot release.
//
// An item is taken at a rising edge where start is high and busy is low.
// With req_type low the key (protocol, host, peer_port) is looked up; on a
// miss it is written into the lowest free slot, or the table is reported
// full. With req_type high the slot named by free_slot is released.
// Exactly one result comes back per item: slot_index and status are valid
// for the single cycle in which done is high, and the receiver cannot hold
// it off. busy stays high from acceptance until the result cycle ends.
//
// A release result is strobed in the cycle right after the accepting edge.
// A lookup result is strobed once the scan ends: the key store is a
// single-read-port RAM with a registered read, so the read of slot 0 is
// started first, then one entry is compared per cycle, and the result
// register follows. A hit ends the scan early.
//
// Synchronous reset clears all valid bits at once and returns the
// sequencer to idle; no clearing pass over the key store is needed.
module address_table_lookup_insert (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        req_type,
  input  logic        protocol,
  input  logic [31:0] host,
  input  logic [15:0] peer_port,
  input  logic [3:0]  free_slot,
  output logic        done,
  output logic [3:0]  slot_index,
  output logic [1:0]  status
);

  // Sequencer states.
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic state;

  // Valid bits live in flops so reset clears them all at once.
  logic [atli_pkg::ENTRIES-1:0] valid;

  // The key under lookup, captured when the item is accepted.
  atli_pkg::key_t req_key;

  // Scan bookkeeping: cnt is the next slot to fetch, chk_idx the slot whose
  // key is on the RAM read port this cycle.
  atli_pkg::slot_t cnt;
  atli_pkg::slot_t chk_idx;
  logic            chk_vld;
  logic            have_free;
  atli_pkg::slot_t free_at;

  atli_pkg::key_t  rd_key;
  logic            hit;
  logic            ram_we;
  logic            accept;
  logic            scan_last;
  atli_pkg::slot_t rel_idx;
  logic            rel_ok;
  logic            done_next;

  assign accept    = start && !busy;
  assign busy      = (state != ST_IDLE) || done;
  assign scan_last = chk_vld && (chk_idx == atli_pkg::slot_t'(atli_pkg::ENTRIES - 1));
  assign ram_we    = (state == ST_SCAN) && !hit && scan_last && have_free;

  // A release answers right away; a lookup answers on a hit or at the end
  // of the scan.
  assign done_next = (state == ST_IDLE) ? (accept && (req_type == atli_pkg::REQ_FREE))
                                        : (hit || scan_last);

  // A release index beyond the table counts as an unused slot.
  assign rel_idx = atli_pkg::slot_t'(free_slot);
  assign rel_ok  = (32'(free_slot) < atli_pkg::ENTRIES) && valid[rel_idx];

  atli_ram #(
    .WIDTH (atli_pkg::KEY_W),
    .DEPTH (atli_pkg::ENTRIES)
  ) u_key_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (free_at),
    .wdata (req_key),
    .raddr (cnt),
    .rdata (rd_key)
  );

  atli_cmp u_cmp (
    .req_key     (req_key),
    .entry_key   (rd_key),
    .entry_valid (chk_vld && valid[chk_idx]),
    .hit         (hit)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      valid     <= '0;
      done      <= 1'b0;
      chk_vld   <= 1'b0;
      have_free <= 1'b0;
      cnt       <= '0;
    end else begin
      done <= done_next;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (req_type == atli_pkg::REQ_FREE) begin
              slot_index <= free_slot;
              if (rel_ok) begin
                valid[rel_idx] <= 1'b0;
                status         <= atli_pkg::STATUS_FOUND;
              end else begin
                status <= atli_pkg::STATUS_UNUSED;
              end
            end else begin
              req_key   <= {protocol, host, peer_port};
              cnt       <= '0;
              chk_vld   <= 1'b0;
              have_free <= 1'b0;
              free_at   <= '0;
              state     <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (hit) begin
            // Matching valid entry: report its slot.
            slot_index <= 4'(chk_idx);
            status     <= atli_pkg::STATUS_FOUND;
            state      <= ST_IDLE;
          end else if (scan_last) begin
            // Whole table seen without a match: insert or report full.
            state <= ST_IDLE;
            if (have_free) begin
              valid[free_at] <= 1'b1;
              slot_index     <= 4'(free_at);
              status         <= atli_pkg::STATUS_INSERTED;
            end else begin
              slot_index <= 4'd0;
              status     <= atli_pkg::STATUS_FULL;
            end
          end else begin
            // Fetch the next slot and note the lowest free one on the way.
            chk_vld <= 1'b1;
            chk_idx <= cnt;
            cnt     <= cnt + 1'b1;
            if (!have_free && !valid[cnt]) begin
              have_free <= 1'b1;
              free_at   <= cnt;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

/* rtl/core/atli_ram.sv */
module atli_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/atli_cmp.sv */
// Shared key compare unit: one stored entry against the request key per cycle.
module atli_cmp (
  input  atli_pkg::key_t req_key,
  input  atli_pkg::key_t entry_key,
  input  logic           entry_valid,
  output logic           hit
);

  assign hit = entry_valid && (req_key == entry_key);

endmodule

/* sim/tb_top.sv */
// Self-checking bench for the peer address table. A shadow copy of the valid
// bits and keys predicts the slot and status of every item when the block
// accepts it. Expected outcomes wait in order until their done strobe comes.
module tb_top;

  // The longest legal run with no handshake is a full scan plus the
  // sender's longest gap. The limit allows many times that.
  localparam int IDLE_LIMIT    = 2000;
  // Cycles allowed after the last result before the verdict.
  localparam int SETTLE_CYCLES = atli_pkg::ENTRIES + 8;
  localparam int RANDOM_ITEMS  = 725;
  localparam int KEY_POOL      = 20;

  typedef struct packed {
    logic [3:0] slot;
    logic [1:0] status;
  } outcome_t;

  // Every input has a known value from time zero. Reset is active high.
  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        start     = 1'b0;
  logic        req_type  = atli_pkg::REQ_FIND;
  logic        protocol  = 1'b0;
  logic [31:0] host      = '0;
  logic [15:0] peer_port = '0;
  logic [3:0]  free_slot = '0;
  logic        busy;
  logic        done;
  logic [3:0]  slot_index;
  logic [1:0]  status;

  address_table_lookup_insert dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .req_type   (req_type),
    .protocol   (protocol),
    .host       (host),
    .peer_port  (peer_port),
    .free_slot  (free_slot),
    .done       (done),
    .slot_index (slot_index),
    .status     (status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow table. Keys are only ever read where the valid bit is set, so an
  // entry that was never written is never compared.
  logic           shadow_valid [atli_pkg::ENTRIES];
  atli_pkg::key_t shadow_key   [atli_pkg::ENTRIES];
  outcome_t       pending_outcomes [$];

  int  errors = 0;
  int  items_sent = 0;
  int  results_seen = 0;
  int  status_seen [4] = '{0, 0, 0, 0};
  // When set, the sender offers items back to back with no gaps.
  bit  back_to_back = 1'b0;

  function automatic atli_pkg::key_t pack_key(input logic p, input logic [31:0] h,
                                              input logic [15:0] pt);
    return {p, h, pt};
  endfunction

  function automatic atli_pkg::key_t random_key();
    return {1'($urandom), 32'($urandom), 16'($urandom)};
  endfunction

  // Applies one item to the shadow table and returns what the block must
  // report for it. A release names a slot directly; a lookup scans from
  // slot 0 upward and stops at the first valid entry with an equal key,
  // remembering the lowest free slot in case nothing matches.
  function automatic outcome_t predict_outcome(input logic rq, input atli_pkg::key_t key,
                                               input logic [3:0] fs);
    outcome_t res;
    bit       hit;
    bit       have_free;
    int       free_at;
    res.slot   = '0;
    res.status = atli_pkg::STATUS_FULL;
    hit        = 1'b0;
    have_free  = 1'b0;
    free_at    = 0;
    if (rq == atli_pkg::REQ_FREE) begin
      res.slot = fs;
      if (int'(fs) < atli_pkg::ENTRIES && shadow_valid[fs]) begin
        shadow_valid[fs] = 1'b0;
        res.status = atli_pkg::STATUS_FOUND;
      end else begin
        // Releasing a slot that holds nothing, or one past the end of the
        // table, is reported and otherwise ignored.
        res.status = atli_pkg::STATUS_UNUSED;
      end
    end else begin
      for (int i = 0; i < atli_pkg::ENTRIES && !hit; i++) begin
        if (shadow_valid[i] && shadow_key[i] == key) begin
          hit = 1'b1;
          res.slot = 4'(i);
        end else if (!have_free && !shadow_valid[i]) begin
          have_free = 1'b1;
          free_at = i;
        end
      end
      if (hit) begin
        res.status = atli_pkg::STATUS_FOUND;
      end else if (have_free) begin
        shadow_valid[free_at] = 1'b1;
        shadow_key[free_at]   = key;
        res.slot   = 4'(free_at);
        res.status = atli_pkg::STATUS_INSERTED;
      end else begin
        // Table full: nothing changes and the slot reads as zero.
        res.slot   = '0;
        res.status = atli_pkg::STATUS_FULL;
      end
    end
    return res;
  endfunction

  // Offers one item and returns at the edge that accepts it. The fields
  // change at that same edge only if the next item follows with no gap,
  // which is safe because busy is already rising.
  task automatic send_item(input logic rq, input atli_pkg::key_t key,
                           input logic [3:0] fs);
    int gap;
    gap = back_to_back ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start     <= 1'b1;
    req_type  <= rq;
    protocol  <= key[atli_pkg::KEY_W-1];
    host      <= key[atli_pkg::PORT_W +: atli_pkg::HOST_W];
    peer_port <= key[atli_pkg::PORT_W-1:0];
    free_slot <= fs;
    do @(posedge clk); while (busy);
    pending_outcomes.push_back(predict_outcome(rq, key, fs));
    items_sent++;
  endtask

  // Lookups carry a random release slot and releases a random key, so the
  // unused fields toggle too and must not matter.
  task automatic send_find(input atli_pkg::key_t key);
    send_item(atli_pkg::REQ_FIND, key, 4'($urandom));
  endtask

  task automatic send_free(input logic [3:0] fs);
    send_item(atli_pkg::REQ_FREE, random_key(), fs);
  endtask

  // Holds the sender off until every outstanding result has come back.
  task automatic wait_for_drain();
    start <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
  endtask

  // Keys at the extremes, and keys that differ from a stored one in only
  // the protocol bit or one host bit, must each get a slot of their own.
  task automatic test_key_extremes();
    send_find(pack_key(1'b0, 32'h0000_0000, 16'h0000));
    send_find(pack_key(1'b1, 32'hFFFF_FFFF, 16'hFFFF));
    send_find(pack_key(1'b0, 32'h0000_0000, 16'h0000));
    send_find(pack_key(1'b0, 32'hFFFF_FFFF, 16'hFFFF));
    send_find(pack_key(1'b1, 32'h0000_0000, 16'h0000));
    send_find(pack_key(1'b0, 32'h0000_0001, 16'h0000));
    wait_for_drain();
  endtask

  // A release of a live slot, a second release of the same slot, a release
  // of a slot never filled, and reuse of the hole by the next insert.
  task automatic test_release_cases();
    send_free(4'd1);
    send_free(4'd1);
    send_free(4'd15);
    send_find(pack_key(1'b1, 32'hFFFF_FFFF, 16'hFFFF));
    wait_for_drain();
  endtask

  // Fills every slot, then checks that a new key reports a full table while
  // a stored key is still found, and that a release makes room again.
  task automatic test_table_full();
    int room;
    room = 0;
    for (int i = 0; i < atli_pkg::ENTRIES; i++) begin
      if (!shadow_valid[i]) room++;
    end
    repeat (room + 1) send_find(random_key());
    send_find(pack_key(1'b1, 32'h0000_0000, 16'h0000));
    send_free(4'd9);
    send_find(random_key());
    wait_for_drain();
  endtask

  // Mostly lookups from a small pool of keys, so that hits, inserts, a full
  // table and releases all recur. Near misses flip one bit of a pooled key.
  task automatic test_random_traffic(input int count);
    atli_pkg::key_t pool [KEY_POOL];
    atli_pkg::key_t key;
    int             pick;
    for (int n = 0; n < count; n++) begin
      if (n % 200 == 0) begin
        foreach (pool[k]) pool[k] = random_key();
      end
      // Alternate between stretches with random gaps and without any.
      if (n % 50 == 0) back_to_back = ($urandom_range(0, 3) == 0);
      if (n % 150 == 149) wait_for_drain();
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        send_find(pool[$urandom_range(0, KEY_POOL - 1)]);
      end else if (pick < 68) begin
        send_find(random_key());
      end else if (pick < 75) begin
        key = pool[$urandom_range(0, KEY_POOL - 1)];
        key[$urandom_range(0, atli_pkg::KEY_W - 1)] ^= 1'b1;
        send_find(key);
      end else begin
        send_free(4'($urandom));
      end
    end
    back_to_back = 1'b0;
  endtask

  // Each strobed result is compared with the oldest expectation. Outputs are
  // sampled at the edge, before the block updates them.
  always @(posedge clk) begin : result_check
    outcome_t want;
    if (!rst && done) begin
      results_seen++;
      if (pending_outcomes.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, got slot_index=%0d status=%0d",
                 $time, slot_index, status);
      end else begin
        want = pending_outcomes.pop_front();
        if (slot_index !== want.slot) begin
          errors++;
          $display("%0t: slot_index mismatch, expected %0d, got %0d",
                   $time, want.slot, slot_index);
        end
        if (status !== want.status) begin
          errors++;
          $display("%0t: status mismatch, expected %0d, got %0d",
                   $time, want.status, status);
        end
        if (!$isunknown(status)) status_seen[status]++;
      end
    end
  end

  // Ends the run if neither an item nor a result moves for too long.
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((!rst && start && !busy) || (!rst && done)) idle = 0;
      else idle++;
    end
    $display("%0t: timeout, nothing moved for %0d cycles", $time, IDLE_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : main_sequence
    foreach (shadow_valid[i]) shadow_valid[i] = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_key_extremes();
    test_release_cases();
    test_table_full();
    test_random_traffic(RANDOM_ITEMS);

    start <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    // Any stray strobe after the last expected result is still caught.
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_outcomes.size() != 0) errors++;

    $display("Sent %0d items and checked %0d results.", items_sent, results_seen);
    $display("Outcomes: %0d found or released, %0d inserted, %0d full, %0d unused slot.",
             status_seen[atli_pkg::STATUS_FOUND], status_seen[atli_pkg::STATUS_INSERTED],
             status_seen[atli_pkg::STATUS_FULL], status_seen[atli_pkg::STATUS_UNUSED]);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/atli_pkg.sv
rtl/core/atli_ram.sv
rtl/core/atli_cmp.sv
rtl/core/address_table_lookup_insert.sv
sim/tb_top.sv
